FILE: rtl/brsi_pkg.sv
// Shared constants and types for the block range index stepper.
package brsi_pkg;

	localparam int ID_W        = 48;
	localparam int COUNT_BITS  = 12;
	localparam int NUM_COUNTS  = 4;
	localparam int MAX_DIMS    = 4;
	localparam int DIMS_W      = 3;
	localparam int GTOT_W      = 11;
	localparam int GIDX_W      = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int DIG_W       = $clog2(NUM_COUNTS);
	localparam int BITS_PER_ST = 8;
	localparam int ST_PER_DIV  = ID_W / BITS_PER_ST;
	localparam int DIV_ST      = (NUM_COUNTS - 1) * ST_PER_DIV;
	localparam int BIT_CNT_W   = $clog2(ID_W);
	localparam int PROD_IN_W   = 36;

	localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GTOTAL  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GINDEX  = 3'd6;

	typedef enum logic [2:0] {
		ST_MUL,
		ST_DIV,
		ST_FIRST,
		ST_LAST,
		ST_IDLE
	} setup_state_t;

	typedef struct packed {
		logic                                     busy;
		logic                                     single;
		logic                                     empty;
		logic [DIMS_W-1:0]                        dused;
		logic [GIDX_W-1:0]                        gidx;
		logic [ID_W-1:0]                          first;
		logic [ID_W-1:0]                          last;
		logic [NUM_COUNTS-1:0][COUNT_BITS-1:0]    count;
	} cfg_t;

	typedef struct packed {
		logic                                     ok;
		logic [ID_W-1:0]                          id;
		logic [ID_W-1:0]                          rest;
		logic [COUNT_BITS-1:0]                    rem;
		logic [NUM_COUNTS-1:0][COUNT_BITS-1:0]    coord;
	} stage_t;

endpackage

FILE: rtl/brsi_ifs.sv
// Request, result and configuration channel interfaces.
interface brsi_req_if;
	logic                      valid;
	logic                      ready;
	logic                      start_req;
	logic [brsi_pkg::ID_W-1:0] previous_id;
	modport source (output valid, start_req, previous_id, input ready);
	modport sink (input valid, start_req, previous_id, output ready);
endinterface

interface brsi_res_if;
	logic                            valid;
	logic                            ready;
	logic                            valid_res;
	logic [brsi_pkg::ID_W-1:0]       next_id;
	logic [brsi_pkg::COUNT_BITS-1:0] coord_0;
	logic [brsi_pkg::COUNT_BITS-1:0] coord_1;
	logic [brsi_pkg::COUNT_BITS-1:0] coord_2;
	logic [brsi_pkg::COUNT_BITS-1:0] coord_3;
	modport source (output valid, valid_res, next_id, coord_0, coord_1, coord_2, coord_3,
		input ready);
	modport sink (input valid, valid_res, next_id, coord_0, coord_1, coord_2, coord_3,
		output ready);
endinterface

interface brsi_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [brsi_pkg::CFG_IDX_W-1:0]  index;
	logic [brsi_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/brsi_cfg.sv
// Configuration registers and the sequencer that works out this group's id range.
module brsi_cfg (
	input  logic          clk,
	input  logic          arst_n,
	brsi_cfg_if.sink      cfg,
	output brsi_pkg::cfg_t cfg_st
);
	import brsi_pkg::*;

	logic [DIMS_W-1:0]                     dims_q;
	logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] count_q;
	logic [GTOT_W-1:0]                     gtot_q;
	logic [GIDX_W-1:0]                     gidx_q;

	setup_state_t          state_q, state_d;
	logic [DIG_W-1:0]      step_q;
	logic [BIT_CNT_W-1:0]  bit_q;
	logic [ID_W-1:0]       prod_q;
	logic [ID_W-1:0]       quo_q;
	logic [GTOT_W-1:0]     rem_q;
	logic [ID_W-1:0]       first_q;
	logic [ID_W-1:0]       last_q;
	logic                  empty_q;

	logic                  wr;
	logic [DIMS_W-1:0]     dused;
	logic [PROD_IN_W-1:0]  base;
	logic [COUNT_BITS-1:0] factor;
	logic [GTOT_W:0]       trial;
	logic                  ge;
	logic [BIT_CNT_W-1:0]  bit_idx;
	logic                  many;
	logic                  empty_c;
	logic [ID_W-1:0]       last_c;
	logic [ID_W-1:0]       first_c;
	logic [ID_W-1:0]       extra;
	logic                  busy;

	localparam logic [BIT_CNT_W-1:0] TOP_BIT = BIT_CNT_W'(ID_W - 1);
	localparam logic [DIG_W-1:0]     LAST_STEP = DIG_W'(NUM_COUNTS - 1);

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;
	assign dused     = (dims_q > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_q;

	assign base    = (step_q == '0) ? PROD_IN_W'(1) : prod_q[PROD_IN_W-1:0];
	assign factor  = ({1'b0, step_q} < dused) ? count_q[step_q] : COUNT_BITS'(1);
	assign bit_idx = TOP_BIT - bit_q;
	assign trial   = {rem_q, prod_q[bit_idx]};
	assign ge      = trial >= {1'b0, gtot_q};

	always_comb begin
		many    = {{(ID_W-GTOT_W){1'b0}}, gtot_q} > prod_q;
		empty_c = (gtot_q == '0) || (prod_q == '0);
		if (many) begin
			empty_c = empty_c || ({{(ID_W-GIDX_W){1'b0}}, gidx_q} >= prod_q);
		end else begin
			empty_c = empty_c || ({1'b0, gidx_q} >= gtot_q);
		end
		extra = ({1'b0, gidx_q} == gtot_q - GTOT_W'(1)) ?
			{{(ID_W-GTOT_W){1'b0}}, rem_q} : '0;
		if (many) begin
			first_c = {{(ID_W-GIDX_W){1'b0}}, gidx_q};
			last_c  = first_c;
		end else begin
			first_c = first_q;
			last_c  = first_q + quo_q - ID_W'(1) + extra;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_MUL:   if (step_q == LAST_STEP) state_d = ST_DIV;
			ST_DIV:   if (bit_q == TOP_BIT) state_d = ST_FIRST;
			ST_FIRST: state_d = ST_LAST;
			ST_LAST:  state_d = ST_IDLE;
			ST_IDLE:  state_d = ST_IDLE;
			default:  state_d = ST_MUL;
		endcase
		if (wr) state_d = ST_MUL;
	end

	always_comb begin
		case (state_q)
			ST_IDLE: busy = 1'b0;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= DIMS_W'(1);
			count_q <= {NUM_COUNTS{COUNT_BITS'(1)}};
			gtot_q  <= GTOT_W'(1);
			gidx_q  <= '0;
			state_q <= ST_MUL;
			step_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			if (wr) begin
				case (cfg.index)
					REG_DIMS:    dims_q     <= cfg.data[DIMS_W-1:0];
					REG_COUNT_0: count_q[0] <= cfg.data[COUNT_BITS-1:0];
					REG_COUNT_1: count_q[1] <= cfg.data[COUNT_BITS-1:0];
					REG_COUNT_2: count_q[2] <= cfg.data[COUNT_BITS-1:0];
					REG_COUNT_3: count_q[3] <= cfg.data[COUNT_BITS-1:0];
					REG_GTOTAL:  gtot_q     <= cfg.data[GTOT_W-1:0];
					REG_GINDEX:  gidx_q     <= cfg.data[GIDX_W-1:0];
					default: ;
				endcase
				step_q <= '0;
				bit_q  <= '0;
			end else begin
				if (state_q == ST_MUL) step_q <= step_q + DIG_W'(1);
				if (state_q == ST_DIV) bit_q <= bit_q + BIT_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				prod_q <= ID_W'(base * factor);
				rem_q  <= '0;
				quo_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? GTOT_W'(trial - {1'b0, gtot_q}) : trial[GTOT_W-1:0];
				quo_q <= {quo_q[ID_W-2:0], ge};
			end
			ST_FIRST: first_q <= ID_W'(quo_q * gidx_q);
			ST_LAST: begin
				empty_q <= empty_c;
				first_q <= first_c;
				last_q  <= last_c;
			end
			default: ;
		endcase
	end

	assign cfg_st.busy   = busy;
	assign cfg_st.single = (dused == '0);
	assign cfg_st.empty  = empty_q;
	assign cfg_st.dused  = dused;
	assign cfg_st.gidx   = gidx_q;
	assign cfg_st.first  = first_q;
	assign cfg_st.last   = last_q;
	assign cfg_st.count  = count_q;

endmodule

FILE: rtl/brsi_divstage.sv
// One pipeline stage of the coordinate decode: eight restoring divide steps.
module brsi_divstage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [brsi_pkg::DIG_W-1:0] digit,
	input  logic                     first_st,
	input  logic                     last_st,
	input  brsi_pkg::cfg_t           cfg_st,
	input  logic                     v_in,
	input  brsi_pkg::stage_t         d_in,
	input  logic                     rdy_out,
	output logic                     rdy_in,
	output logic                     v_s1,
	output brsi_pkg::stage_t         d_s1
);
	import brsi_pkg::*;

	stage_t                d_c;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] r;
	logic [ID_W-1:0]       q;
	logic [COUNT_BITS:0]   t;
	logic                  use_digit;

	assign cnt       = cfg_st.count[digit];
	assign use_digit = cfg_st.dused > {{(DIMS_W-DIG_W){1'b0}}, digit};
	assign rdy_in    = !v_s1 || rdy_out;

	always_comb begin
		d_c = d_in;
		r   = first_st ? '0 : d_in.rem;
		q   = d_in.rest;
		t   = '0;
		for (int i = 0; i < BITS_PER_ST; i++) begin
			t = {r, q[ID_W-1]};
			q = {q[ID_W-2:0], 1'b0};
			if (t >= {1'b0, cnt}) begin
				r    = COUNT_BITS'(t - {1'b0, cnt});
				q[0] = 1'b1;
			end else begin
				r = t[COUNT_BITS-1:0];
			end
		end
		// invalid requests pass through with all coordinates at zero
		if (use_digit && d_in.ok) begin
			d_c.rest = q;
			d_c.rem  = r;
			if (last_st) d_c.coord[digit] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_in) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_in && v_in) d_s1 <= d_c;
	end

endmodule

FILE: rtl/brsi_decode.sv
// Mixed-radix decode pipeline: innermost digit first, one stage per eight quotient bits.
module brsi_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  brsi_pkg::cfg_t   cfg_st,
	input  logic             in_valid,
	input  brsi_pkg::stage_t in_data,
	output logic             in_ready,
	output logic             out_valid,
	output brsi_pkg::stage_t out_data,
	input  logic             out_ready
);
	import brsi_pkg::*;

	logic [DIV_ST:0] v;
	logic [DIV_ST:0] rdy;
	stage_t          d [DIV_ST+1];

	assign v[0]        = in_valid;
	assign d[0]        = in_data;
	assign in_ready    = rdy[0];
	assign rdy[DIV_ST] = out_ready;
	assign out_valid   = v[DIV_ST];
	assign out_data    = d[DIV_ST];

	for (genvar k = 0; k < DIV_ST; k++) begin : g_st
		localparam int J = NUM_COUNTS - 1 - k / ST_PER_DIV;
		localparam int P = k % ST_PER_DIV;
		brsi_divstage u_st (
			.clk      (clk),
			.arst_n   (arst_n),
			.digit    (DIG_W'(J)),
			.first_st (P == 0),
			.last_st  (P == ST_PER_DIV - 1),
			.cfg_st   (cfg_st),
			.v_in     (v[k]),
			.d_in     (d[k]),
			.rdy_out  (rdy[k+1]),
			.rdy_in   (rdy[k]),
			.v_s1     (v[k+1]),
			.d_s1     (d[k+1])
		);
	end

endmodule

FILE: rtl/block_range_index_stepper.sv
// Top level of the block range index stepper.
//
// Hands out the grid point ids owned by this worker group, one per request.
// Channels: req (start_req, previous_id), res (valid_res, next_id, coord_0..3),
// cfg (index, data) for the seven setup registers. All use valid/ready.
// One front stage picks the id, then 18 stages of restoring division (eight
// bits each, six per digit) peel off the three inner coordinates. One request
// per cycle is taken while res is not stalled and no setup is running.
// After reset and after every cfg write a setup sequencer runs four multiply
// steps for the grid size, a 48-bit bit-serial divide by the group count, then
// the first and last range steps; req.ready stays low meanwhile.
// cfg writes are always taken and must only come while no request is in flight.
// When res is stalled each stage holds its request; bubbles fill and the
// input keeps flowing until every stage holds a request.
module block_range_index_stepper (
	input  logic      clk,
	input  logic      arst_n,
	brsi_cfg_if.sink  cfg,
	brsi_req_if.sink  req,
	brsi_res_if.source res
);
	import brsi_pkg::*;

	cfg_t        cfg_st;
	logic        v_s1;
	stage_t      d_s1;
	stage_t      d_c;
	logic        s1_en;
	logic        dec_ready;
	logic        dec_valid;
	stage_t      dec_data;
	logic [ID_W:0] prev1;
	logic        ok;

	brsi_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_st (cfg_st)
	);

	assign s1_en     = !v_s1 || dec_ready;
	assign req.ready = s1_en && !cfg_st.busy;
	assign prev1     = {1'b0, req.previous_id} + (ID_W+1)'(1);

	always_comb begin
		if (cfg_st.single) begin
			ok = req.start_req && (cfg_st.gidx == '0);
		end else begin
			ok = !cfg_st.empty && (req.start_req || (prev1 <= {1'b0, cfg_st.last}));
		end
		d_c.ok    = ok;
		d_c.id    = '0;
		if (ok && !cfg_st.single) begin
			d_c.id = req.start_req ? cfg_st.first : prev1[ID_W-1:0];
		end
		d_c.rest  = d_c.id;
		d_c.rem   = '0;
		d_c.coord = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= req.valid && req.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) d_s1 <= d_c;
	end

	brsi_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_st    (cfg_st),
		.in_valid  (v_s1),
		.in_data   (d_s1),
		.in_ready  (dec_ready),
		.out_valid (dec_valid),
		.out_data  (dec_data),
		.out_ready (res.ready)
	);

	assign res.valid     = dec_valid;
	assign res.valid_res = dec_data.ok;
	assign res.next_id   = dec_data.id;
	assign res.coord_0   = (cfg_st.dused != '0) ? dec_data.rest[COUNT_BITS-1:0] : '0;
	assign res.coord_1   = dec_data.coord[1];
	assign res.coord_2   = dec_data.coord[2];
	assign res.coord_3   = dec_data.coord[3];

	a_id_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.valid_res && !cfg_st.single |-> res.next_id <= cfg_st.last)
		else $error("id handed out beyond the end of the range");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.valid_res |-> res.next_id == '0 && res.coord_0 == '0 &&
		res.coord_1 == '0 && res.coord_2 == '0 && res.coord_3 == '0)
		else $error("invalid result carries nonzero fields");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !dec_ready |=> v_s1 && $stable(d_s1))
		else $error("front stage lost a stalled request");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_st.busy |-> !(req.valid && req.ready))
		else $error("request taken during range setup");

endmodule

FILE: tb/brsi_tb_ifs_note.sv
// Shared testbench types for the block range index stepper bench.
`timescale 1ns / 1ps
package brsi_tb_pkg;
	import brsi_pkg::*;

	typedef struct packed {
		logic              start_req;
		logic [ID_W-1:0]   previous_id;
	} id_req_t;

	typedef struct packed {
		logic                                  valid_res;
		logic [ID_W-1:0]                       next_id;
		logic [NUM_COUNTS-1:0][COUNT_BITS-1:0] coord;
	} id_res_t;
endpackage

FILE: tb/tb_top.sv
// Testbench top: random and directed requests against a grid-partition predictor.
`timescale 1ns / 1ps
module tb_top;
	import brsi_pkg::*;
	import brsi_tb_pkg::*;

	logic clk;
	logic arst_n;

	brsi_cfg_if cfg();
	brsi_req_if req();
	brsi_res_if res();

	block_range_index_stepper DUT (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .req(req.sink), .res(res.source)
	);

	// Shadow copy of the setup registers
	logic [DIMS_W-1:0]     grid_dims;
	logic [COUNT_BITS-1:0] grid_count [NUM_COUNTS];
	logic [GTOT_W-1:0]     grp_total;
	logic [GIDX_W-1:0]     grp_index;

	id_req_t pending_reqs[$];
	id_res_t expected_ids[$];
	int      mismatches;
	int      hold_cycles;
	bit      hold_start;
	int      send_gap;
	int      recv_gap;
	logic [ID_W-1:0] blk_first, blk_last;
	bit      blk_ok;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void find_block(output bit ok, output logic [ID_W-1:0] first,
		output logic [ID_W-1:0] last);
		logic [63:0] total, per, extra;
		int d;
		d = (grid_dims > MAX_DIMS) ? MAX_DIMS : grid_dims;
		total = 1;
		ok = 0;
		first = '0;
		last = '0;
		for (int i = 0; i < d; i++)
			total = total * grid_count[i];
		if (grp_total == 0 || total == 0)
			return;
		if (grp_total > total) begin
			if (grp_index >= total)
				return;
			first = grp_index;
			last = grp_index;
			ok = 1;
			return;
		end
		if (grp_index >= grp_total)
			return;
		per = total / grp_total;
		extra = total % grp_total;
		first = per * grp_index;
		last = per * grp_index + per - 1;
		if (grp_index == grp_total - 1)
			last = last + extra;
		ok = 1;
	endfunction

	function automatic id_res_t predict_next_id(id_req_t r);
		id_res_t o;
		bit ok;
		logic [ID_W-1:0] first, last;
		logic [63:0] under [NUM_COUNTS];
		logic [63:0] rest, nxt;
		int d;
		o = '0;
		d = (grid_dims > MAX_DIMS) ? MAX_DIMS : grid_dims;
		if (d == 0) begin
			o.valid_res = r.start_req && grp_index == 0;
			return o;
		end
		find_block(ok, first, last);
		if (!ok)
			return o;
		nxt = {16'd0, r.previous_id} + 1;
		if (r.start_req) begin
			o.valid_res = 1;
			o.next_id = first;
		end else if (nxt <= {16'd0, last}) begin
			o.valid_res = 1;
			o.next_id = nxt[ID_W-1:0];
		end
		if (!o.valid_res)
			return o;
		under[d-1] = 1;
		for (int i = d - 1; i > 0; i--)
			under[i-1] = under[i] * grid_count[i];
		rest = o.next_id;
		for (int i = 0; i + 1 < d; i++) begin
			if (under[i] != 0) begin
				o.coord[NUM_COUNTS-1-i] = rest / under[i];
				rest = rest % under[i];
			end
		end
		o.coord[NUM_COUNTS-1-(d-1)] = rest;
		return o;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.start_req <= 1'b0;
			req.previous_id <= '0;
			send_gap <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_ids.push_back(predict_next_id({req.start_req, req.previous_id}));
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0 || pending_reqs.size() == 0) begin
					req.valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					id_req_t r;
					r = pending_reqs.pop_front();
					req.valid <= 1'b1;
					req.start_req <= r.start_req;
					req.previous_id <= r.previous_id;
					send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
				end
			end
		end
	end

	// Long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
		end else if (hold_start) begin
			hold_cycles <= 200;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			recv_gap <= 0;
			mismatches <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_ids.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result id=%0h", res.next_id);
					mismatches <= mismatches + 1;
				end else begin
					id_res_t e;
					e = expected_ids.pop_front();
					if (e.valid_res !== res.valid_res || e.next_id !== res.next_id ||
						e.coord[3] !== res.coord_0 || e.coord[2] !== res.coord_1 ||
						e.coord[1] !== res.coord_2 || e.coord[0] !== res.coord_3) begin
						if (mismatches < 10)
							$display("mismatch exp v=%0d id=%0h c=%0h/%0h/%0h/%0h got v=%0d id=%0h c=%0h/%0h/%0h/%0h",
								e.valid_res, e.next_id, e.coord[3], e.coord[2], e.coord[1],
								e.coord[0], res.valid_res, res.next_id, res.coord_0,
								res.coord_1, res.coord_2, res.coord_3);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (hold_start || hold_cycles > 0) begin
				res.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if (res.valid && res.ready)
					recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req.valid || expected_ids.size() != 0)
			@(negedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_DIMS:    grid_dims = value[DIMS_W-1:0];
			REG_COUNT_0: grid_count[0] = value[COUNT_BITS-1:0];
			REG_COUNT_1: grid_count[1] = value[COUNT_BITS-1:0];
			REG_COUNT_2: grid_count[2] = value[COUNT_BITS-1:0];
			REG_COUNT_3: grid_count[3] = value[COUNT_BITS-1:0];
			REG_GTOTAL:  grp_total = value[GTOT_W-1:0];
			REG_GINDEX:  grp_index = value[GIDX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(int d, int c0, int c1, int c2, int c3, int gt, int gi);
		write_reg(REG_DIMS, d);
		write_reg(REG_COUNT_0, c0);
		write_reg(REG_COUNT_1, c1);
		write_reg(REG_COUNT_2, c2);
		write_reg(REG_COUNT_3, c3);
		write_reg(REG_GTOTAL, gt);
		write_reg(REG_GINDEX, gi);
	endtask

	function automatic logic [ID_W-1:0] rand_id();
		return {$urandom, $urandom} & {ID_W{1'b1}};
	endfunction

	// Walks the block from its first id, with a few stray ids mixed in
	task automatic add_walk(int n);
		logic [ID_W-1:0] p;
		find_block(blk_ok, blk_first, blk_last);
		pending_reqs.push_back('{1'b1, rand_id()});
		p = blk_first;
		for (int i = 1; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: pending_reqs.push_back('{1'b0, rand_id()});
				1: pending_reqs.push_back('{1'b0, blk_last});
				2: pending_reqs.push_back('{1'b0, blk_last - 1});
				3: pending_reqs.push_back('{1'b1, p});
				default: begin
					pending_reqs.push_back('{1'b0, p});
					p = p + 1;
				end
			endcase
		end
	endtask

	initial begin
		int c [4];
		int gt;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		hold_start = 1'b0;
		grid_dims = 1;
		for (int i = 0; i < NUM_COUNTS; i++)
			grid_count[i] = 1;
		grp_total = 1;
		grp_index = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting, then directed corner cases
		pending_reqs.push_back('{1'b1, '0});
		pending_reqs.push_back('{1'b0, '0});
		pending_reqs.push_back('{1'b0, {ID_W{1'b1}}});
		wait_drained();
		set_grid(4, 4095, 4095, 4095, 4095, 1024, 1023);
		pending_reqs.push_back('{1'b1, '0});
		pending_reqs.push_back('{1'b0, {ID_W{1'b1}}});
		pending_reqs.push_back('{1'b0, {ID_W{1'b1}} - 2});
		pending_reqs.push_back('{1'b0, 48'h5555_5555_5555});
		pending_reqs.push_back('{1'b0, 48'hAAAA_AAAA_AAAA});
		wait_drained();
		set_grid(0, 7, 7, 7, 7, 0, 0);
		pending_reqs.push_back('{1'b1, '0});
		pending_reqs.push_back('{1'b0, '0});
		wait_drained();
		write_reg(REG_GINDEX, 1);
		pending_reqs.push_back('{1'b1, '0});
		wait_drained();
		set_grid(7, 2, 3, 0, 5, 3, 0);
		pending_reqs.push_back('{1'b1, '0});
		pending_reqs.push_back('{1'b0, 3});
		wait_drained();
		set_grid(2, 3, 2, 1, 1, 0, 0);
		pending_reqs.push_back('{1'b1, '0});
		wait_drained();
		write_reg(REG_GTOTAL, 0);
		pending_reqs.push_back('{1'b1, '0});
		wait_drained();
		set_grid(2, 3, 2, 1, 1, 10, 4);
		pending_reqs.push_back('{1'b1, '0});
		wait_drained();
		write_reg(REG_GINDEX, 7);
		pending_reqs.push_back('{1'b1, '0});
		wait_drained();
		set_grid(3, 5, 3, 2, 1, 4, 3);
		pending_reqs.push_back('{1'b1, '0});
		pending_reqs.push_back('{1'b0, 28});
		pending_reqs.push_back('{1'b0, 29});
		pending_reqs.push_back('{1'b0, 30});
		wait_drained();
		set_grid(4, 3, 4, 5, 6, 5, 6);
		pending_reqs.push_back('{1'b1, '0});
		wait_drained();

		// Random settings, each followed by a walk through its block with stray ids
		for (int ph = 0; ph < 42; ph++) begin
			for (int i = 0; i < 4; i++)
				c[i] = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095) :
					($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 12);
			gt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1024) : $urandom_range(1, 8);
			set_grid($urandom_range(0, 7), c[0], c[1], c[2], c[3], gt,
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) :
				$urandom_range(0, gt));
			add_walk(40);
			if (ph == 10) begin
				// receiver holds off so the pipeline backs up
				@(posedge clk);
				hold_start <= 1'b1;
				@(posedge clk);
				hold_start <= 1'b0;
			end
			wait_drained();
		end
		wait_drained();
		if (mismatches == 0 && expected_ids.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
